/* sv/ttrc_pkg.sv */
package ttrc_pkg;

  localparam int unsigned TermW = 16;
  localparam int unsigned PosW = 8;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ProdW = 25;

  localparam logic [TermW-1:0] PrevInit = 16'd1;
  localparam logic [TermW-1:0] CurrInit = 16'd0;
  localparam logic [PosW-1:0] PosInit = 8'd0;
  localparam logic [PosW-1:0] PosFirst = 8'd1;
  localparam logic [TermW-1:0] FirstOffset = 16'd7;
  localparam logic [TermW-1:0] ModMax = 16'hFFFF;

  // recurrence state carried from byte to byte
  typedef struct packed {
    logic [TermW-1:0] prev;
    logic [TermW-1:0] curr;
    logic [PosW-1:0] pos;
    logic started;
  } state_t;

  // 17 * pos mod 256
  function automatic logic [PosW-1:0] alpha_of(input logic [PosW-1:0] pos);
    logic [PosW-1:0] sh;
    sh = pos << 4;
    return sh + pos;
  endfunction

  // 31 * pos mod 256
  function automatic logic [PosW-1:0] beta_of(input logic [PosW-1:0] pos);
    logic [PosW-1:0] sh;
    sh = pos << 5;
    return sh - pos;
  endfunction

  // v mod 65535 by end-around folding, since 2^16 is 1 mod 65535
  function automatic logic [TermW-1:0] mod_fold(input logic [ProdW-1:0] v);
    logic [TermW:0] s1;
    logic [TermW:0] s2;
    s1 = {8'd0, v[ProdW-1:TermW]} + {1'b0, v[TermW-1:0]};
    s2 = {16'd0, s1[TermW]} + {1'b0, s1[TermW-1:0]};
    return (s2[TermW-1:0] == ModMax) ? '0 : s2[TermW-1:0];
  endfunction

endpackage

/* sv/ttrc_step.sv */
module ttrc_step (
  input  logic [ttrc_pkg::ByteW-1:0] data_byte,
  input  ttrc_pkg::state_t           cur_state,
  output ttrc_pkg::state_t           nxt_state
);

  logic [ttrc_pkg::PosW-1:0]  alpha;
  logic [ttrc_pkg::PosW-1:0]  beta;
  logic [ttrc_pkg::ByteW:0]   factor;
  logic [ttrc_pkg::ProdW-1:0] x;
  logic [ttrc_pkg::ProdW-1:0] y;
  logic [ttrc_pkg::ProdW-1:0] diff;
  logic [ttrc_pkg::TermW-1:0] folded;
  logic [ttrc_pkg::TermW-1:0] new_term;
  logic                       under;

  // coefficients from the byte index
  assign alpha = ttrc_pkg::alpha_of(cur_state.pos);
  assign beta  = ttrc_pkg::beta_of(cur_state.pos);

  // the two products
  assign factor = {1'b0, data_byte} + {1'b0, alpha};
  assign x = {16'd0, factor} * {9'd0, cur_state.curr};
  assign y = {17'd0, beta} * {9'd0, cur_state.prev};

  // difference with the 64-bit wrap: a negative -d gives -(d-1) mod 65535
  assign under = x < y;
  assign diff  = under ? (y - x - 25'd1) : (x - y);
  assign folded = ttrc_pkg::mod_fold(diff);
  assign new_term = (under && folded != '0) ? ~folded : folded;

  // first byte loads the seed terms, later bytes shift the terms along
  always_comb begin
    if (!cur_state.started) begin
      nxt_state.prev    = ttrc_pkg::PrevInit;
      nxt_state.curr    = {8'd0, data_byte} + ttrc_pkg::FirstOffset;
      nxt_state.pos     = ttrc_pkg::PosFirst;
      nxt_state.started = 1'b1;
    end else begin
      nxt_state.prev    = cur_state.curr;
      nxt_state.curr    = new_term;
      nxt_state.pos     = cur_state.pos + 8'd1;
      nxt_state.started = 1'b1;
    end
  end

endmodule

/* sv/three_term_recurrence_checksum.sv */
// Three-term recurrence checksum over a byte stream.
// Input channel: in_valid/in_ready with data_byte and last; one byte per item,
// last marks the final byte of a message. Output channel: out_valid/out_ready
// with checksum, one item per message, sent after its last byte.
// Path: a byte taken sits in the input register; as it moves on, it updates
// the recurrence terms and, for a last byte, loads the result register that
// offers checksum. Throughput: one byte per cycle unless a last byte waits for
// room in the result register, set by the combinational term update (two
// small products, a subtract and a fold mod 65535) that feeds itself.
// Stall: while a result waits in the result register, bytes that are not last
// keep flowing; a last byte holds in the input register until the result is
// taken, and input ready drops only then.
// Reset (rst, synchronous): empties both registers and rearms the recurrence
// with prev = 1, cur = 0, index 0. After each last byte the block rearms.
module three_term_recurrence_checksum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ttrc_pkg::ByteW-1:0] data_byte,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ttrc_pkg::TermW-1:0] checksum
);

  logic                       s1_valid;
  logic [ttrc_pkg::ByteW-1:0] s1_byte;
  logic                       s1_last;
  logic                       s1_fire;
  logic                       out_free;
  ttrc_pkg::state_t           st;
  ttrc_pkg::state_t           st_next;

  // a last byte needs room in the result register
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last;
    end
  end

  ttrc_step u_step (
    .data_byte (s1_byte),
    .cur_state (st),
    .nxt_state (st_next)
  );

  // recurrence state, rearmed after a last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev    <= ttrc_pkg::PrevInit;
      st.curr    <= ttrc_pkg::CurrInit;
      st.pos     <= ttrc_pkg::PosInit;
      st.started <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        st.prev    <= ttrc_pkg::PrevInit;
        st.curr    <= ttrc_pkg::CurrInit;
        st.pos     <= ttrc_pkg::PosInit;
        st.started <= 1'b0;
      end else begin
        st <= st_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      checksum <= st_next.curr;
    end
  end

  // a finished message leaves the recurrence rearmed
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> (!st.started && st.pos == ttrc_pkg::PosInit
                              && st.prev == ttrc_pkg::PrevInit))
    else $error("recurrence not rearmed after last byte");

  // terms stay reduced below the modulus
  a_curr_range: assert property (@(posedge clk) disable iff (rst)
    st.curr != ttrc_pkg::ModMax)
    else $error("current term out of range");

  // an idle recurrence holds its seed values
  a_idle_seed: assert property (@(posedge clk) disable iff (rst)
    !st.started |-> (st.pos == ttrc_pkg::PosInit && st.prev == ttrc_pkg::PrevInit))
    else $error("idle recurrence lost its seed");

  // a pending result is never overwritten by a new last byte
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(s1_fire && s1_last))
    else $error("result overwritten while stalled");

  // offered results are reduced
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> checksum != ttrc_pkg::ModMax)
    else $error("checksum out of range");

endmodule

/* tb/three_term_recurrence_checksum_test.sv */
`timescale 1ns / 1ps

module three_term_recurrence_checksum_test;

  localparam longint unsigned TermMod = 65535;
  localparam int unsigned AlphaMul = 17;
  localparam int unsigned BetaMul = 31;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomItems = 480;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [ttrc_pkg::ByteW-1:0] data_byte;
  logic last;
  logic out_valid;
  logic out_ready;
  logic [ttrc_pkg::TermW-1:0] checksum;

  // own copy of the recurrence
  logic [ttrc_pkg::TermW-1:0] sum_prev;
  logic [ttrc_pkg::TermW-1:0] sum_curr;
  logic [ttrc_pkg::PosW-1:0] sum_pos;
  logic sum_open;

  logic [ttrc_pkg::TermW-1:0] checksum_q[$];
  int unsigned errors;
  int unsigned items_sent;
  bit tx_stall_en;
  bit rx_stall_en;
  bit reset_done;

  three_term_recurrence_checksum DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .checksum(checksum)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(0, 2);
  endfunction

  // one recurrence step, difference wraps as 64-bit unsigned
  function automatic logic [ttrc_pkg::TermW-1:0] next_term(
      input logic [ttrc_pkg::ByteW-1:0] b,
      input logic [ttrc_pkg::PosW-1:0] pos,
      input logic [ttrc_pkg::TermW-1:0] curr,
      input logic [ttrc_pkg::TermW-1:0] prev);
    logic [7:0] alpha;
    logic [7:0] beta;
    longint unsigned x;
    longint unsigned y;
    longint unsigned dlt;
    longint unsigned r;
    alpha = 8'((AlphaMul * pos) % 256);
    beta = 8'((BetaMul * pos) % 256);
    x = (longint'(b) + longint'(alpha)) * longint'(curr);
    y = longint'(beta) * longint'(prev);
    if (x >= y) begin
      r = (x - y) % TermMod;
    end else begin
      dlt = y - x;
      r = (dlt - 1) % TermMod;
      r = (r == 0) ? 0 : TermMod - r;
    end
    return r[ttrc_pkg::TermW-1:0];
  endfunction

  // fold one accepted byte into the prediction
  task automatic absorb_byte(input logic [ttrc_pkg::ByteW-1:0] b, input logic l);
    logic [ttrc_pkg::TermW-1:0] nv;
    if (!sum_open) begin
      sum_prev = ttrc_pkg::PrevInit;
      sum_curr = {8'd0, b} + ttrc_pkg::FirstOffset;
      sum_pos = ttrc_pkg::PosFirst;
      sum_open = 1'b1;
    end else begin
      nv = next_term(b, sum_pos, sum_curr, sum_prev);
      sum_prev = sum_curr;
      sum_curr = nv;
      sum_pos = sum_pos + 8'd1;
    end
    if (l) begin
      checksum_q.push_back(sum_curr);
      sum_prev = ttrc_pkg::PrevInit;
      sum_curr = ttrc_pkg::CurrInit;
      sum_pos = ttrc_pkg::PosInit;
      sum_open = 1'b0;
    end
  endtask

  // offer one byte and wait for the handshake
  task automatic send_byte(input logic [ttrc_pkg::ByteW-1:0] b, input logic l);
    int unsigned gap;
    gap = tx_stall_en ? gap_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= l;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, l);
    items_sent++;
  endtask

  function automatic logic [ttrc_pkg::ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one-byte messages: result is byte + 7
  task automatic test_single_bytes();
    tx_stall_en = 1'b1;
    rx_stall_en = 1'b1;
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    send_byte(8'd128, 1'b1);
  endtask

  // short messages built from extreme bytes
  task automatic test_extreme_messages();
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd255, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b1);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b1);
  endtask

  // messages back to back with no gaps, state must rearm every time
  task automatic test_rearm();
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    send_byte(8'd1, 1'b1);
    send_byte(8'd254, 1'b0);
    send_byte(8'd3, 1'b1);
    send_byte(8'd7, 1'b0);
    send_byte(8'd7, 1'b0);
    send_byte(8'd7, 1'b1);
    rx_stall_en = 1'b1;
    send_byte(8'd9, 1'b1);
    send_byte(8'd200, 1'b1);
  endtask

  // random messages, one long enough to wrap the index
  task automatic test_random_stream();
    int unsigned start;
    int unsigned msg_idx;
    int unsigned long_at;
    int unsigned len;
    start = items_sent;
    msg_idx = 0;
    long_at = $urandom_range(0, 30);
    while (items_sent - start < RandomItems) begin
      if (msg_idx == long_at) begin
        len = $urandom_range(257, 300);
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      tx_stall_en = ($urandom_range(0, 4) != 0);
      rx_stall_en = ($urandom_range(0, 4) != 0);
      for (int unsigned k = 0; k < len; k++) begin
        send_byte(pick_byte(), k == len - 1);
      end
      msg_idx++;
    end
  endtask

  // result side ready with random stalls
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (reset_done) begin
        if (hold != 0) begin
          hold--;
        end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
          out_ready <= 1'b0;
          hold = gap_len();
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (checksum_q.size() == 0) begin
        $display("%0t unexpected checksum: expected none, got %0d", $time, checksum);
        errors++;
      end else if (checksum !== checksum_q[0]) begin
        $display("%0t checksum mismatch: expected %0d, got %0d",
                 $time, checksum_q[0], checksum);
        errors++;
        void'(checksum_q.pop_front());
      end else begin
        void'(checksum_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (reset_done);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t watchdog: no handshake for %0d cycles", $time, StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // sequence
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    last <= 1'b0;
    errors = 0;
    items_sent = 0;
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    reset_done = 1'b0;
    sum_prev = ttrc_pkg::PrevInit;
    sum_curr = ttrc_pkg::CurrInit;
    sum_pos = ttrc_pkg::PosInit;
    sum_open = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    test_single_bytes();
    test_extreme_messages();
    test_rearm();
    test_random_stream();

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    rx_stall_en = 1'b0;
    while (checksum_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (checksum_q.size() != 0) begin
      $display("%0t %0d checksum item(s) never arrived, oldest expected %0d",
               $time, checksum_q.size(), checksum_q[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* three_term_recurrence_checksum.f */
sv/ttrc_pkg.sv
sv/ttrc_step.sv
sv/three_term_recurrence_checksum.sv
tb/three_term_recurrence_checksum_test.sv
